@@ hw/rtl/vrp_pkg.sv @@
// Shared types, widths and the quarter-wave sine table of the vertex rotate/project block.
// No dependencies.
`timescale 1ns / 1ps
package vrp_pkg;

	localparam int FRAC_BITS       = 12;
	localparam int SINE_TABLE_BITS = 10;

	localparam int COORD_W = 16;
	localparam int REG_W   = 15;
	localparam int SIN_W   = FRAC_BITS + 2;
	localparam int QS_W    = FRAC_BITS + 1;
	localparam int QN      = (1 << (SINE_TABLE_BITS - 2)) + 1;
	localparam int QIDX_W  = SINE_TABLE_BITS - 1;
	localparam int PROD_W  = COORD_W + SIN_W;
	localparam int R1_W    = PROD_W + 1 - FRAC_BITS;
	localparam int P2_W    = R1_W + SIN_W;
	localparam int R2_W    = P2_W + 1 - FRAC_BITS;
	localparam int ZC_W    = R2_W + 1;
	localparam int DIV_W   = ZC_W - 1;
	localparam int NUM_W   = R2_W + REG_W + 1;
	localparam int NCELLS  = NUM_W;

	localparam logic [1:0] REG_DIST  = 2'd0;
	localparam logic [1:0] REG_FOCAL = 2'd1;
	localparam logic [1:0] REG_NEAR  = 2'd2;

	localparam logic [REG_W-1:0] DIST_RST  = 15'd16384;
	localparam logic [REG_W-1:0] FOCAL_RST = 15'd4506;
	localparam logic [REG_W-1:0] NEAR_RST  = 15'd410;

	typedef logic [QN-1:0][QS_W-1:0] qtab_t;
	typedef logic signed [SIN_W-1:0] sin_t;

	// word handed from cell to cell through the divider
	typedef struct packed {
		logic [NUM_W-1:0]   nx;
		logic [NUM_W-1:0]   ny;
		logic [NUM_W-1:0]   qx;
		logic [NUM_W-1:0]   qy;
		logic [DIV_W-1:0]   rx;
		logic [DIV_W-1:0]   ry;
		logic [DIV_W-1:0]   d;
		logic               neg_x;
		logic               neg_y;
		logic               clamped;
		logic [COORD_W-1:0] depth;
	} div_word_t;

	function automatic longint quarter_sine(longint q);
		longint x, x2, t, v, s;
		x  = q <<< 16;
		x2 = (x * x) >>> 30;
		t  = 64'sd688904866 - ((64'sd76016977 * x2) >>> 30);
		v  = 64'sd1686629713 - ((x2 * t) >>> 30);
		s  = (x * v) >>> 30;
		return (s + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
	endfunction

	function automatic qtab_t build_qtab();
		qtab_t tab;
		longint s;
		for (int j = 0; j < QN; j++) begin
			s = quarter_sine(longint'(j) <<< (16 - SINE_TABLE_BITS));
			tab[j] = QS_W'(s);
		end
		return tab;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	// full-turn sine from the quarter table, angle truncated to the table index
	function automatic sin_t sine_lookup(logic [COORD_W-1:0] phase);
		logic [SINE_TABLE_BITS-1:0] k;
		logic [1:0]                 quad;
		logic [QIDX_W-1:0]          j;
		logic [QIDX_W-1:0]          r;
		sin_t                       s;
		k    = phase[COORD_W-1 -: SINE_TABLE_BITS];
		quad = k[SINE_TABLE_BITS-1 -: 2];
		r    = QIDX_W'(k[SINE_TABLE_BITS-3:0]);
		j    = quad[0] ? QIDX_W'((QN - 1) - int'(r)) : r;
		s    = $signed(SIN_W'(QTAB[j]));
		return quad[1] ? -s : s;
	endfunction

endpackage

@@ hw/rtl/vrp_if.sv @@
// Valid/ready channels of the vertex rotate/project block: vertex in, projected vertex out.
// No dependencies.
`timescale 1ns / 1ps
interface vrp_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] vertex_x;
	logic signed [15:0] vertex_y;
	logic signed [15:0] vertex_z;
	logic [15:0]        angle_about_x;
	logic [15:0]        angle_about_y;
	modport source(output valid, vertex_x, vertex_y, vertex_z, angle_about_x, angle_about_y,
		input ready);
	modport sink(input valid, vertex_x, vertex_y, vertex_z, angle_about_x, angle_about_y,
		output ready);
endinterface

interface vrp_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] proj_x;
	logic signed [15:0] proj_y;
	logic signed [15:0] proj_depth;
	logic               near_clamped;
	logic               saturated;
	modport source(output valid, proj_x, proj_y, proj_depth, near_clamped, saturated,
		input ready);
	modport sink(input valid, proj_x, proj_y, proj_depth, near_clamped, saturated,
		output ready);
endinterface

@@ hw/rtl/vrp_rotate.sv @@
// Front pipeline: sine lookup, two rotations, view depth clamp, numerator set-up.
// Depends on vrp_pkg.
`timescale 1ns / 1ps
module vrp_rotate import vrp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  logic signed [COORD_W-1:0] vx,
	input  logic signed [COORD_W-1:0] vy,
	input  logic signed [COORD_W-1:0] vz,
	input  logic [COORD_W-1:0]        ax,
	input  logic [COORD_W-1:0]        ay,
	input  logic [REG_W-1:0]          cam_dist,
	input  logic [REG_W-1:0]          focal,
	input  logic [REG_W-1:0]          near,
	output logic                      dn_valid,
	input  logic                      dn_ready,
	output div_word_t                 dn_word
);
	localparam int NS = 7;

	logic [NS-1:0] v_q;
	logic [NS-1:0] rdy;

	always_comb begin
		rdy[NS-1] = ~v_q[NS-1] | dn_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			rdy[k] = ~v_q[k] | rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= up_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign up_ready = rdy[0];
	assign dn_valid = v_q[NS-1];

	// stage 1: table lookup
	logic signed [COORD_W-1:0] vx_s1, vy_s1, vz_s1;
	sin_t sx_s1, cx_s1, sy_s1, cy_s1;
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			vx_s1 <= vx;
			vy_s1 <= vy;
			vz_s1 <= vz;
			sx_s1 <= sine_lookup(ax);
			cx_s1 <= sine_lookup(ax + 16'd16384);
			sy_s1 <= sine_lookup(ay);
			cy_s1 <= sine_lookup(ay + 16'd16384);
		end
	end

	// stage 2: products for the x rotation
	logic signed [PROD_W-1:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [COORD_W-1:0] vx_s2;
	sin_t sy_s2, cy_s2;
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			pa_s2 <= PROD_W'(cx_s1) * PROD_W'(vy_s1);
			pb_s2 <= PROD_W'(sx_s1) * PROD_W'(vz_s1);
			pc_s2 <= PROD_W'(sx_s1) * PROD_W'(vy_s1);
			pd_s2 <= PROD_W'(cx_s1) * PROD_W'(vz_s1);
			vx_s2 <= vx_s1;
			sy_s2 <= sy_s1;
			cy_s2 <= cy_s1;
		end
	end

	// stage 3: round the x rotation
	localparam logic signed [PROD_W:0] RND1 = (PROD_W+1)'(1 << (FRAC_BITS - 1));
	logic signed [PROD_W:0] ysum, zsum;
	logic signed [R1_W-1:0] y1_s3, z1_s3;
	logic signed [COORD_W-1:0] vx_s3;
	sin_t sy_s3, cy_s3;
	assign ysum = (PROD_W+1)'(pa_s2) - (PROD_W+1)'(pb_s2) + RND1;
	assign zsum = (PROD_W+1)'(pc_s2) + (PROD_W+1)'(pd_s2) + RND1;
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			y1_s3 <= R1_W'(ysum >>> FRAC_BITS);
			z1_s3 <= R1_W'(zsum >>> FRAC_BITS);
			vx_s3 <= vx_s2;
			sy_s3 <= sy_s2;
			cy_s3 <= cy_s2;
		end
	end

	// stage 4: products for the y rotation
	logic signed [P2_W-1:0] qa_s4, qb_s4, qc_s4, qd_s4;
	logic signed [R1_W-1:0] y1_s4;
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			qa_s4 <= P2_W'(cy_s3) * P2_W'(vx_s3);
			qb_s4 <= P2_W'(sy_s3) * P2_W'(z1_s3);
			qc_s4 <= P2_W'(cy_s3) * P2_W'(z1_s3);
			qd_s4 <= P2_W'(sy_s3) * P2_W'(vx_s3);
			y1_s4 <= y1_s3;
		end
	end

	// stage 5: round the y rotation
	localparam logic signed [P2_W:0] RND2 = (P2_W+1)'(1 << (FRAC_BITS - 1));
	logic signed [P2_W:0] xsum2, zsum2;
	logic signed [R2_W-1:0] x2_s5, z2_s5;
	logic signed [R1_W-1:0] y1_s5;
	assign xsum2 = (P2_W+1)'(qa_s4) + (P2_W+1)'(qb_s4) + RND2;
	assign zsum2 = (P2_W+1)'(qc_s4) - (P2_W+1)'(qd_s4) + RND2;
	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			x2_s5 <= R2_W'(xsum2 >>> FRAC_BITS);
			z2_s5 <= R2_W'(zsum2 >>> FRAC_BITS);
			y1_s5 <= y1_s4;
		end
	end

	// stage 6: view depth, near clamp, depth output
	logic [REG_W-1:0]       nearv;
	logic signed [ZC_W-1:0] zc_raw, zc_near, zc_sel;
	logic                   clamp_c;
	logic signed [ZC_W:0]   dd;
	logic signed [ZC_W:0]   dq;
	logic [COORD_W-1:0]     depth_c;
	assign nearv   = (near == '0) ? REG_W'(1) : near;
	assign zc_raw  = ZC_W'(z2_s5) + $signed(ZC_W'(cam_dist));
	assign zc_near = $signed(ZC_W'(nearv));
	assign clamp_c = zc_raw < zc_near;
	assign zc_sel  = clamp_c ? zc_near : zc_raw;
	assign dd      = (ZC_W+1)'(zc_sel) - $signed((ZC_W+1)'(cam_dist)) + (ZC_W+1)'(2);
	assign dq      = dd >>> 2;
	always_comb begin
		if (dq > $signed((ZC_W+1)'(32767))) begin
			depth_c = 16'h7fff;
		end else if (dq < -$signed((ZC_W+1)'(32768))) begin
			depth_c = 16'h8000;
		end else begin
			depth_c = dq[COORD_W-1:0];
		end
	end

	logic [DIV_W-1:0]       d_s6;
	logic                   clamped_s6;
	logic [COORD_W-1:0]     depth_s6;
	logic signed [R2_W-1:0] x2_s6;
	logic signed [R1_W-1:0] y1_s6;
	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			d_s6       <= DIV_W'(zc_sel);
			clamped_s6 <= clamp_c;
			depth_s6   <= depth_c;
			x2_s6      <= x2_s5;
			y1_s6      <= y1_s5;
		end
	end

	// stage 7: numerators, magnitude plus half divisor for round to nearest
	logic signed [NUM_W-1:0] mx, my;
	logic [NUM_W-1:0]        half;
	div_word_t               w_s7;
	assign mx   = NUM_W'(x2_s6) * $signed(NUM_W'(focal));
	assign my   = NUM_W'(y1_s6) * $signed(NUM_W'(focal));
	assign half = NUM_W'(d_s6 >> 1);
	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			w_s7.nx      <= (mx[NUM_W-1] ? NUM_W'(-mx) : NUM_W'(mx)) + half;
			w_s7.ny      <= (my[NUM_W-1] ? NUM_W'(-my) : NUM_W'(my)) + half;
			w_s7.qx      <= '0;
			w_s7.qy      <= '0;
			w_s7.rx      <= '0;
			w_s7.ry      <= '0;
			w_s7.d       <= d_s6;
			w_s7.neg_x   <= mx[NUM_W-1];
			w_s7.neg_y   <= my[NUM_W-1];
			w_s7.clamped <= clamped_s6;
			w_s7.depth   <= depth_s6;
		end
	end
	assign dn_word = w_s7;

endmodule

@@ hw/rtl/vrp_div_cell.sv @@
// One restoring-division cell: settles one quotient bit for the x and y lanes.
// Depends on vrp_pkg.
`timescale 1ns / 1ps
module vrp_div_cell import vrp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_ready,
	input  div_word_t up_word,
	output logic      dn_valid,
	input  logic      dn_ready,
	output div_word_t dn_word
);
	logic         v_q;
	div_word_t    w_q;
	div_word_t    nxt;
	logic [DIV_W:0] tx, ty;
	logic         bx, by;

	assign up_ready = ~v_q | dn_ready;

	always_comb begin
		// bring down the next numerator bit, subtract where it fits
		tx = {up_word.rx, up_word.nx[NUM_W-1]};
		ty = {up_word.ry, up_word.ny[NUM_W-1]};
		bx = tx >= {1'b0, up_word.d};
		by = ty >= {1'b0, up_word.d};
		nxt    = up_word;
		nxt.nx = up_word.nx << 1;
		nxt.ny = up_word.ny << 1;
		nxt.qx = {up_word.qx[NUM_W-2:0], bx};
		nxt.qy = {up_word.qy[NUM_W-2:0], by};
		nxt.rx = bx ? DIV_W'(tx - {1'b0, up_word.d}) : DIV_W'(tx);
		nxt.ry = by ? DIV_W'(ty - {1'b0, up_word.d}) : DIV_W'(ty);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			w_q <= nxt;
		end
	end

	assign dn_valid = v_q;
	assign dn_word  = w_q;

endmodule

@@ hw/rtl/vertex_rotate_project.sv @@
// Top level: configuration registers, front pipeline, division cell row, output register.
// Depends on vrp_pkg, vrp_if, vrp_rotate and vrp_div_cell.
//
//   channel | dir | handshake    | word
//   vin     | in  | valid/ready  | vertex x, y, z and two angles
//   vout    | out | valid/ready  | projected x, y, depth, near and saturation flags
//   cfg     | in  | cfg_we       | register index and 15-bit value
//
// One vertex a cycle while the output is taken; the path is the front pipeline, the row
// of one-bit division cells and the output register. Every stage holds its own valid and
// refills when its successor moves, so bubbles close up and a stalled output only
// backs up the stages behind it. Reset clears the valid bits and loads register defaults.
`timescale 1ns / 1ps
module vertex_rotate_project import vrp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	vrp_in_if.sink           vin,
	vrp_out_if.source        vout,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [REG_W-1:0] cfg_data
);
	logic [REG_W-1:0] dist_q, focal_q, near_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q  <= DIST_RST;
			focal_q <= FOCAL_RST;
			near_q  <= NEAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIST:  dist_q  <= cfg_data;
				REG_FOCAL: focal_q <= cfg_data;
				REG_NEAR:  near_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [NCELLS:0] c_valid;
	logic [NCELLS:0] c_ready;
	div_word_t       c_word [NCELLS+1];

	vrp_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vin.valid),
		.up_ready (vin.ready),
		.vx       (vin.vertex_x),
		.vy       (vin.vertex_y),
		.vz       (vin.vertex_z),
		.ax       (vin.angle_about_x),
		.ay       (vin.angle_about_y),
		.cam_dist (dist_q),
		.focal    (focal_q),
		.near     (near_q),
		.dn_valid (c_valid[0]),
		.dn_ready (c_ready[0]),
		.dn_word  (c_word[0])
	);

	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		vrp_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (c_valid[i]),
			.up_ready (c_ready[i]),
			.up_word  (c_word[i]),
			.dn_valid (c_valid[i+1]),
			.dn_ready (c_ready[i+1]),
			.dn_word  (c_word[i+1])
		);
	end

	// sign and saturate the quotients
	div_word_t          fw;
	logic               sat_x, sat_y;
	logic [COORD_W-1:0] px, py;
	assign fw = c_word[NCELLS];

	always_comb begin
		if (fw.neg_x) begin
			sat_x = fw.qx > NUM_W'(32768);
			px    = sat_x ? 16'h8000 : (~fw.qx[COORD_W-1:0] + 16'd1);
		end else begin
			sat_x = fw.qx > NUM_W'(32767);
			px    = sat_x ? 16'h7fff : fw.qx[COORD_W-1:0];
		end
		if (fw.neg_y) begin
			sat_y = fw.qy > NUM_W'(32768);
			py    = sat_y ? 16'h8000 : (~fw.qy[COORD_W-1:0] + 16'd1);
		end else begin
			sat_y = fw.qy > NUM_W'(32767);
			py    = sat_y ? 16'h7fff : fw.qy[COORD_W-1:0];
		end
	end

	logic               ov_q;
	logic [COORD_W-1:0] px_q, py_q, pd_q;
	logic               clamp_q, sat_q;

	assign c_ready[NCELLS] = ~ov_q | vout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (c_ready[NCELLS]) begin
			ov_q <= c_valid[NCELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (c_ready[NCELLS]) begin
			px_q    <= px;
			py_q    <= py;
			pd_q    <= fw.depth;
			clamp_q <= fw.clamped;
			sat_q   <= sat_x | sat_y;
		end
	end

	assign vout.valid        = ov_q;
	assign vout.proj_x       = $signed(px_q);
	assign vout.proj_y       = $signed(py_q);
	assign vout.proj_depth   = $signed(pd_q);
	assign vout.near_clamped = clamp_q;
	assign vout.saturated    = sat_q;

endmodule

@@ tb/tb_vertex_rotate_project.sv @@
// Self-checking bench for vertex_rotate_project: rotation, projection, clamps and back-pressure.
// Depends on vrp_pkg, vrp_if and the vertex_rotate_project RTL.
`timescale 1ns / 1ps
module tb;
	import vrp_pkg::*;

	typedef struct {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] pd;
		logic               nc;
		logic               sat;
	} proj_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;

	vrp_in_if  vin();
	vrp_out_if vout();

	vertex_rotate_project DUT (.clk(clk), .arst_n(arst_n), .vin(vin), .vout(vout),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	longint cam_dist, focal, near_lim;
	proj_word_t expected_q[$];
	int errors = 0, n_sent = 0, n_got = 0, n_clamp = 0, n_sat = 0;
	int hold_off = 0;
	bit busy_sink = 1'b1;

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rnd_sh(longint v, int s);
		return floor_sh(v + (64'sd1 <<< (s - 1)), s);
	endfunction

	function automatic longint poly_sine(longint q);
		longint x, x2, t, v, s;
		x  = q <<< 16;
		x2 = (x * x) >>> 30;
		t  = 64'sd688904866 - ((64'sd76016977 * x2) >>> 30);
		v  = 64'sd1686629713 - ((x2 * t) >>> 30);
		s  = (x * v) >>> 30;
		return (s + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
	endfunction

	function automatic longint angle_sine(logic [15:0] phase);
		logic [15:0] p;
		longint r, q, s;
		p = (phase >> (16 - SINE_TABLE_BITS)) << (16 - SINE_TABLE_BITS);
		r = longint'(p[13:0]);
		q = p[14] ? 16384 - r : r;
		s = poly_sine(q);
		return p[15] ? -s : s;
	endfunction

	function automatic longint div_nearest(longint n, longint d);
		longint m, q;
		m = n < 0 ? -n : n;
		q = (m + d / 2) / d;
		return n < 0 ? -q : q;
	endfunction

	function automatic logic signed [15:0] clip16(longint v, output bit hit);
		hit = 1'b0;
		if (v > 32767) begin
			hit = 1'b1;
			return 16'sh7fff;
		end
		if (v < -32768) begin
			hit = 1'b1;
			return 16'sh8000;
		end
		return 16'(v);
	endfunction

	function automatic proj_word_t project_vertex(logic signed [15:0] vx, vy, vz,
			logic [15:0] ax, ay);
		proj_word_t w;
		longint sx, cx, sy, cy, y1, z1, x2, z2, nv, zc;
		bit hx, hy, hd;
		sx = angle_sine(ax);
		cx = angle_sine(ax + 16'd16384);
		sy = angle_sine(ay);
		cy = angle_sine(ay + 16'd16384);
		y1 = rnd_sh(cx * vy - sx * vz, FRAC_BITS);
		z1 = rnd_sh(sx * vy + cx * vz, FRAC_BITS);
		x2 = rnd_sh(cy * vx + sy * z1, FRAC_BITS);
		z2 = rnd_sh(cy * z1 - sy * vx, FRAC_BITS);
		nv = near_lim == 0 ? 1 : near_lim;
		zc = z2 + cam_dist;
		w.nc = zc < nv;
		if (w.nc)
			zc = nv;
		w.px = clip16(div_nearest(x2 * focal, zc), hx);
		w.py = clip16(div_nearest(y1 * focal, zc), hy);
		w.pd = clip16(rnd_sh(zc - cam_dist, 2), hd);
		w.sat = hx | hy;
		return w;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// sink: random stalls while busy_sink is set, always ready otherwise, plus the long hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			vout.ready <= 1'b0;
		end else if (!busy_sink) begin
			vout.ready <= 1'b1;
		end else begin
			vout.ready <= ($urandom_range(0, 99) < 70);
		end
	end

	// compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		proj_word_t e;
		if (arst_n && vout.valid && vout.ready) begin
			n_got++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word px=%0d py=%0d", $time, vout.proj_x, vout.proj_y);
			end else begin
				e = expected_q.pop_front();
				if (vout.proj_x !== e.px) begin
					errors++;
					$display("%0t: proj_x exp %0d got %0d", $time, e.px, vout.proj_x);
				end
				if (vout.proj_y !== e.py) begin
					errors++;
					$display("%0t: proj_y exp %0d got %0d", $time, e.py, vout.proj_y);
				end
				if (vout.proj_depth !== e.pd) begin
					errors++;
					$display("%0t: proj_depth exp %0d got %0d", $time, e.pd, vout.proj_depth);
				end
				if (vout.near_clamped !== e.nc) begin
					errors++;
					$display("%0t: near_clamped exp %0b got %0b", $time, e.nc, vout.near_clamped);
				end
				if (vout.saturated !== e.sat) begin
					errors++;
					$display("%0t: saturated exp %0b got %0b", $time, e.sat, vout.saturated);
				end
			end
		end
	end

	task automatic send_vertex(logic signed [15:0] vx, vy, vz, logic [15:0] ax, ay,
			bit gaps = 1'b1);
		proj_word_t w;
		int g;
		g = gaps ? gap_len() : 0;
		repeat (g) begin
			vin.valid <= 1'b0;
			@(posedge clk);
		end
		w = project_vertex(vx, vy, vz, ax, ay);
		if (w.nc) n_clamp++;
		if (w.sat) n_sat++;
		vin.valid <= 1'b1;
		vin.vertex_x <= vx;
		vin.vertex_y <= vy;
		vin.vertex_z <= vz;
		vin.angle_about_x <= ax;
		vin.angle_about_y <= ay;
		do
			@(posedge clk);
		while (!vin.ready);
		expected_q.push_back(w);
		n_sent++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		// drop valid at the accepting edge so the last word is not offered again
		vin.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		// hold for the pipeline latency before touching registers
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DIST:  cam_dist = longint'(val);
			REG_FOCAL: focal = longint'(val);
			REG_NEAR:  near_lim = longint'(val);
			default: ;
		endcase
	endtask

	task automatic set_camera(logic [REG_W-1:0] d, f, n);
		write_reg(REG_DIST, d);
		write_reg(REG_FOCAL, f);
		write_reg(REG_NEAR, n);
	endtask

	task automatic random_vertex();
		logic [15:0] ax, ay;
		logic signed [15:0] vx, vy, vz;
		ax = 16'($urandom);
		ay = 16'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			vx = 16'($urandom);
			vy = 16'($urandom);
			vz = 16'($urandom);
		end else begin
			vx = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
			vy = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
			vz = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
		end
		send_vertex(vx, vy, vz, ax, ay);
	endtask

	task automatic test_directed();
		send_vertex(16'sd0, 16'sd0, 16'sd0, 16'd0, 16'd0);
		send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff, 16'hffff);
		send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 16'h0000, 16'h0000);
		send_vertex(16'sh8000, 16'sh7fff, 16'sh8000, 16'h4000, 16'hc000);
		send_vertex(16'sh7fff, 16'sh8000, 16'sh7fff, 16'h8000, 16'h4000);
		send_vertex(16'sd4096, -16'sd4096, 16'sd8192, 16'h2000, 16'h6000);
		send_vertex(16'sd4096, 16'sd4096, -16'sd16384, 16'd0, 16'd0);
		send_vertex(16'sd30000, -16'sd30000, -16'sd20000, 16'd0, 16'd0);
		send_vertex(16'sd1, -16'sd1, 16'sd1, 16'h003f, 16'h0040);
		send_vertex(16'sd2048, 16'sd2048, 16'sd2048, 16'h5555, 16'haaaa);
		drain();
	endtask

	task automatic test_register_extremes();
		set_camera(15'd0, 15'd32767, 15'd0);
		send_vertex(16'sd4096, 16'sd4096, 16'sd0, 16'd0, 16'd0);
		send_vertex(-16'sd4096, 16'sd100, -16'sd1, 16'd0, 16'd0);
		send_vertex(16'sh7fff, 16'sh8000, 16'sh8000, 16'h1234, 16'h8765);
		drain();
		set_camera(15'd32767, 15'd0, 15'd32767);
		send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'd0, 16'd0);
		send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 16'h4000, 16'h4000);
		drain();
		set_camera(15'd32767, 15'd32767, 15'd1);
		send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'd0, 16'd0);
		send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 16'h8000, 16'd0);
		drain();
	endtask

	task automatic test_random_settings();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_camera(DIST_RST, FOCAL_RST, NEAR_RST);
				1: set_camera(15'd8192, 15'd8192, 15'd205);
				default: set_camera(15'($urandom), 15'($urandom), 15'($urandom));
			endcase
			busy_sink = (ph != 3);
			for (int i = 0; i < 200; i++)
				random_vertex();
			drain();
		end
		busy_sink = 1'b1;
	endtask

	task automatic test_backpressure();
		set_camera(DIST_RST, FOCAL_RST, NEAR_RST);
		hold_off = 150;
		for (int i = 0; i < 80; i++) begin
			logic [15:0] ax, ay;
			ax = 16'($urandom);
			ay = 16'($urandom);
			send_vertex(16'($urandom), 16'($urandom), 16'($urandom), ax, ay, 1'b0);
		end
		drain();
		// sender waits for every result, then a burst with no gaps
		for (int i = 0; i < 50; i++)
			send_vertex(16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 1'b0);
		drain();
	endtask

	initial begin
		vin.valid = 1'b0;
		vin.vertex_x = '0;
		vin.vertex_y = '0;
		vin.vertex_z = '0;
		vin.angle_about_x = '0;
		vin.angle_about_y = '0;
		cam_dist = longint'(DIST_RST);
		focal = longint'(FOCAL_RST);
		near_lim = longint'(NEAR_RST);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_settings();
		test_backpressure();
		$display("Sent %0d vertices, checked %0d words over 11 camera settings", n_sent, n_got);
		$display("Near-clamped cases: %0d, saturated projections: %0d", n_clamp, n_sat);
		if (errors == 0 && expected_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

@@ sim.f @@
hw/rtl/vrp_pkg.sv
hw/rtl/vrp_if.sv
hw/rtl/vrp_rotate.sv
hw/rtl/vrp_div_cell.sv
hw/rtl/vertex_rotate_project.sv
tb/tb_vertex_rotate_project.sv
